@@ hdl/blid_pkg.sv @@
`default_nettype none

package blid_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int VALUE_W      = 32;
  localparam int POS_W        = 6;
  localparam int OP_W         = 2;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [OP_W-1:0] OP_INS_HEAD = 2'd0;
  localparam logic [OP_W-1:0] OP_INS_TAIL = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE   = 2'd2;

  typedef enum logic [1:0] {
    KIND_INS_HEAD,
    KIND_INS_TAIL,
    KIND_DELETE,
    KIND_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                  kind;
    logic signed [VALUE_W-1:0]  value;
    logic [POS_W-1:0]           position;
  } cmd_t;

endpackage

`default_nettype wire

@@ hdl/bounded_list_insert_delete.sv @@
// path: a request passes the queue, dispatch, store read and output register to its first result;
//   a delete at position p first shifts the entries behind p down in the store
// throughput: one result per cycle unless out_stall holds it; the back end takes a new request
//   only once the listing of the one before is done, after any delete shift
// reset: synchronous active low; the list becomes empty, the entry store is not cleared
`default_nettype none

module bounded_list_insert_delete #(
  parameter int CAPACITY = blid_pkg::CAPACITY_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [blid_pkg::OP_W-1:0]            in_op,
  input  wire logic signed [blid_pkg::VALUE_W-1:0]  in_value,
  input  wire logic [blid_pkg::POS_W-1:0]           in_position,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [blid_pkg::VALUE_W-1:0]       out_entry_value,
  output logic [blid_pkg::POS_W-1:0]                out_entry_index,
  output logic                                      out_last_entry,
  output logic                                      out_list_empty,
  output logic                                      out_insert_dropped
);

  logic           push, full, pop, q_valid;
  blid_pkg::cmd_t push_cmd, pop_cmd;

  blid_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_op       (in_op),
    .in_value    (in_value),
    .in_position (in_position),
    .q_push      (push),
    .q_cmd       (push_cmd),
    .q_full      (full)
  );

  blid_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .valid    (q_valid),
    .pop_cmd  (pop_cmd)
  );

  blid_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_valid),
    .q_cmd              (pop_cmd),
    .q_pop              (pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_entry_value    (out_entry_value),
    .out_entry_index    (out_entry_index),
    .out_last_entry     (out_last_entry),
    .out_list_empty     (out_list_empty),
    .out_insert_dropped (out_insert_dropped)
  );

endmodule

`default_nettype wire

@@ hdl/blid_front.sv @@
`default_nettype none

module blid_front (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [blid_pkg::OP_W-1:0]          in_op,
  input  wire logic signed [blid_pkg::VALUE_W-1:0] in_value,
  input  wire logic [blid_pkg::POS_W-1:0]         in_position,
  output logic                                    q_push,
  output blid_pkg::cmd_t                          q_cmd,
  input  wire logic                               q_full
);

  logic           req_vld_r, req_vld_nxt;
  blid_pkg::cmd_t req_cmd_r;
  blid_pkg::cmd_t dec_cmd;
  logic           accept;

  assign in_stall = req_vld_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign q_push   = req_vld_r && !q_full;
  assign q_cmd    = req_cmd_r;

  always_comb begin
    dec_cmd.value    = in_value;
    dec_cmd.position = in_position;
    case (in_op)
      blid_pkg::OP_INS_HEAD: dec_cmd.kind = blid_pkg::KIND_INS_HEAD;
      blid_pkg::OP_INS_TAIL: dec_cmd.kind = blid_pkg::KIND_INS_TAIL;
      blid_pkg::OP_DELETE:   dec_cmd.kind = blid_pkg::KIND_DELETE;
      default:               dec_cmd.kind = blid_pkg::KIND_NOP;
    endcase
  end

  always_comb begin
    req_vld_nxt = req_vld_r;
    if (accept) begin
      req_vld_nxt = 1'b1;
    end else if (q_push) begin
      req_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
    end else begin
      req_vld_r <= req_vld_nxt;
    end
    if (accept) begin
      req_cmd_r <= dec_cmd;
    end
  end

endmodule

`default_nettype wire

@@ hdl/blid_queue.sv @@
`default_nettype none

module blid_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire blid_pkg::cmd_t push_cmd,
  output logic                full,
  input  wire logic           pop,
  output logic                valid,
  output blid_pkg::cmd_t      pop_cmd
);

  localparam int QD   = blid_pkg::QUEUE_DEPTH;
  localparam int QA_W = (QD > 1) ? $clog2(QD) : 1;

  blid_pkg::cmd_t  slot_r [QD];
  logic [QA_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QA_W:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full    = (cnt_r == (QA_W+1)'(QD));
  assign valid   = (cnt_r != '0);
  assign pop_cmd = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QA_W'(QD - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QA_W'(QD - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

@@ hdl/blid_back.sv @@
`default_nettype none

module blid_back #(
  parameter int CAPACITY = blid_pkg::CAPACITY_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                q_valid,
  input  wire blid_pkg::cmd_t                      q_cmd,
  output logic                                     q_pop,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [blid_pkg::VALUE_W-1:0]      out_entry_value,
  output logic [blid_pkg::POS_W-1:0]               out_entry_index,
  output logic                                     out_last_entry,
  output logic                                     out_list_empty,
  output logic                                     out_insert_dropped
);

  localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int POS_W  = blid_pkg::POS_W;
  localparam int VAL_W  = blid_pkg::VALUE_W;
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_LIST
  } state_t;

  // circular store, head_r points at list entry 0
  logic [VAL_W-1:0]  mem [DEPTH];

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [ADDR_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0]  j_r, j_nxt;
  logic              drop_r, drop_nxt;

  logic              sh_pend_r, sh_pend_nxt;
  logic [ADDR_W-1:0] sh_addr_r, sh_addr_nxt;
  logic [VAL_W-1:0]  sh_data_r;

  logic              lst_vld_r, lst_vld_nxt;
  logic [VAL_W-1:0]  lst_data_r;
  logic [CNT_W-1:0]  lst_idx_r, lst_idx_nxt;
  logic              lst_last_r, lst_last_nxt;
  logic              lst_empty_r, lst_empty_nxt;
  logic              lst_drop_r, lst_drop_nxt;

  logic              out_vld_r;
  logic [VAL_W-1:0]  out_value_r;
  logic [POS_W-1:0]  out_idx_r;
  logic              out_last_r, out_empty_r, out_drop_r;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [VAL_W-1:0]  mem_wdata;
  logic              rd_en_lst, rd_en_sh;
  logic [ADDR_W-1:0] rd_addr;

  logic              full;
  logic              lst_load_out, lst_free, out_take;
  logic [CNT_W-1:0]  j_inc;

  assign full         = (cnt_r == CNT_W'(CAPACITY));
  assign out_take     = out_vld_r && !out_stall;
  assign lst_load_out = lst_vld_r && (!out_vld_r || !out_stall);
  assign lst_free     = !lst_vld_r || lst_load_out;
  assign q_pop        = (state_r == ST_IDLE) && q_valid;
  assign j_inc        = j_r + CNT_W'(1);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    head_nxt      = head_r;
    j_nxt         = j_r;
    drop_nxt      = drop_r;
    sh_pend_nxt   = 1'b0;
    sh_addr_nxt   = sh_addr_r;
    lst_vld_nxt   = lst_load_out ? 1'b0 : lst_vld_r;
    lst_idx_nxt   = lst_idx_r;
    lst_last_nxt  = lst_last_r;
    lst_empty_nxt = lst_empty_r;
    lst_drop_nxt  = lst_drop_r;
    mem_we        = 1'b0;
    mem_waddr     = sh_addr_r;
    mem_wdata     = sh_data_r;
    rd_en_lst     = 1'b0;
    rd_en_sh      = 1'b0;
    rd_addr       = head_r + ADDR_W'(j_r);

    // each shifted word is written in the cycle after its read
    if (sh_pend_r) begin
      mem_we = 1'b1;
    end

    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          drop_nxt  = 1'b0;
          j_nxt     = '0;
          state_nxt = ST_LIST;
          case (q_cmd.kind)
            blid_pkg::KIND_INS_HEAD: begin
              if (full) begin
                drop_nxt = 1'b1;
              end else begin
                head_nxt  = head_r - 1'b1;
                mem_we    = 1'b1;
                mem_waddr = head_r - 1'b1;
                mem_wdata = q_cmd.value;
                cnt_nxt   = cnt_r + 1'b1;
              end
            end
            blid_pkg::KIND_INS_TAIL: begin
              if (full) begin
                drop_nxt = 1'b1;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = head_r + ADDR_W'(cnt_r);
                mem_wdata = q_cmd.value;
                cnt_nxt   = cnt_r + 1'b1;
              end
            end
            blid_pkg::KIND_DELETE: begin
              if (CMP_W'(q_cmd.position) < CMP_W'(cnt_r)) begin
                j_nxt     = CNT_W'(q_cmd.position);
                state_nxt = ST_SHIFT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SHIFT: begin
        rd_addr = head_r + ADDR_W'(j_inc);
        if (j_inc < cnt_r) begin
          rd_en_sh    = 1'b1;
          sh_pend_nxt = 1'b1;
          sh_addr_nxt = head_r + ADDR_W'(j_r);
          j_nxt       = j_inc;
        end else begin
          cnt_nxt   = cnt_r - 1'b1;
          j_nxt     = '0;
          state_nxt = ST_LIST;
        end
      end
      ST_LIST: begin
        if (lst_free) begin
          lst_vld_nxt  = 1'b1;
          lst_idx_nxt  = j_r;
          lst_drop_nxt = drop_r;
          if (cnt_r == '0) begin
            lst_empty_nxt = 1'b1;
            lst_last_nxt  = 1'b1;
            state_nxt     = ST_IDLE;
          end else begin
            rd_en_lst     = 1'b1;
            lst_empty_nxt = 1'b0;
            lst_last_nxt  = (j_inc == cnt_r);
            j_nxt         = j_inc;
            if (j_inc == cnt_r) begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en_lst) begin
      lst_data_r <= mem[rd_addr];
    end
    if (rd_en_sh) begin
      sh_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_r     <= '0;
      head_r    <= '0;
      j_r       <= '0;
      drop_r    <= 1'b0;
      sh_pend_r <= 1'b0;
      lst_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      head_r    <= head_nxt;
      j_r       <= j_nxt;
      drop_r    <= drop_nxt;
      sh_pend_r <= sh_pend_nxt;
      lst_vld_r <= lst_vld_nxt;
      if (lst_load_out) begin
        out_vld_r <= 1'b1;
      end else if (out_take) begin
        out_vld_r <= 1'b0;
      end
    end
    sh_addr_r     <= sh_addr_nxt;
    lst_idx_r     <= lst_idx_nxt;
    lst_last_r    <= lst_last_nxt;
    lst_empty_r   <= lst_empty_nxt;
    lst_drop_r    <= lst_drop_nxt;
    if (lst_load_out) begin
      out_value_r <= lst_empty_r ? '0 : lst_data_r;
      out_idx_r   <= POS_W'(lst_idx_r);
      out_last_r  <= lst_last_r;
      out_empty_r <= lst_empty_r;
      out_drop_r  <= lst_drop_r;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_entry_value    = out_value_r;
  assign out_entry_index    = out_idx_r;
  assign out_last_entry     = out_last_r;
  assign out_list_empty     = out_empty_r;
  assign out_insert_dropped = out_drop_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_drop_keeps_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && full && (q_cmd.kind == blid_pkg::KIND_INS_HEAD ||
                      q_cmd.kind == blid_pkg::KIND_INS_TAIL)
    |=> $stable(cnt_r) && drop_r)
    else $error("refused insert changed the list");

  a_empty_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_empty_r |-> out_last_r && out_idx_r == '0 && out_value_r == '0)
    else $error("empty listing malformed");

  a_shift_write: assert property (@(posedge clk) disable iff (!rst_n)
    sh_pend_r |-> state_r == ST_SHIFT)
    else $error("shift write outside delete");

endmodule

`default_nettype wire
